### hw/rtl/ebsd_pkg.sv
// Shared constants, types and defaults for the EMA bank stability detector.
package ebsd_pkg;

  // Bank geometry and field widths.
  localparam int NUM_FILTERS   = 4;
  localparam int SAMPLE_BITS   = 24;
  localparam int GAIN_BITS     = 17;
  localparam int GAIN_FRAC     = 16;
  localparam int TARE_BITS     = 24;
  localparam int THRESH_BITS   = 24;
  localparam int COUNT_BITS    = 8;
  localparam int LEVEL_BITS    = 25;
  localparam int CFG_DATA_BITS = 24;

  // Derived widths for the filter datapath.
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
  localparam int CMP_BITS  = (DIFF_BITS > THRESH_BITS) ? DIFF_BITS : THRESH_BITS;
  localparam int OUT_CALC_A = (SAMPLE_BITS > TARE_BITS) ? SAMPLE_BITS : TARE_BITS;
  localparam int OUT_CALC_BITS = ((OUT_CALC_A > LEVEL_BITS) ? OUT_CALC_A : LEVEL_BITS) + 1;

  // Configuration register map.
  localparam int NUM_CFG_REGS   = NUM_FILTERS + 3;
  localparam int CFG_INDEX_BITS = $clog2(NUM_CFG_REGS);
  localparam int GAIN_IDX_BITS  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_LAST = CFG_INDEX_BITS'(NUM_FILTERS - 1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARE      = CFG_INDEX_BITS'(NUM_FILTERS);
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = CFG_INDEX_BITS'(NUM_FILTERS + 1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT     = CFG_INDEX_BITS'(NUM_FILTERS + 2);

  // Gain of one in Q16 and the saturation point of the settle counters.
  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY    = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [COUNT_BITS-1:0] COUNTER_MAX   = '1;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(3000);
  localparam logic [COUNT_BITS-1:0] COUNT_RESET   = COUNT_BITS'(2);

  localparam logic [GAIN_BITS-1:0] GAIN_DEFAULTS [8] = '{
    17'd65536, 17'd32768, 17'd13107, 17'd6554,
    17'd6554,  17'd6554,  17'd6554,  17'd6554
  };

  // Reset gain of filter i.
  function automatic logic [GAIN_BITS-1:0] gain_default(input int i);
    return GAIN_DEFAULTS[3'(i)];
  endfunction

  // Shared settings seen by every filter lane.
  typedef struct packed {
    logic signed [TARE_BITS-1:0] tare;
    logic [THRESH_BITS-1:0]      threshold;
    logic [COUNT_BITS-1:0]       settle_count;
  } lane_cfg_t;

  // Per-cycle control from the top level to the lanes.
  typedef struct packed {
    logic advance;
    logic primed;
  } lane_ctrl_t;

  // One lane's contribution to a result.
  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] level;
    logic                         steady;
  } lane_res_t;

endpackage

### hw/rtl/ebsd_if.sv
// Stream interfaces for the sample input channel and the result output channel.
interface ebsd_in_if;
  import ebsd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ebsd_out_if;
  import ebsd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [LEVEL_BITS-1:0] level_zero;
  logic signed [LEVEL_BITS-1:0] level_one;
  logic signed [LEVEL_BITS-1:0] level_two;
  logic signed [LEVEL_BITS-1:0] level_three;
  logic                         steady_zero;
  logic                         steady_one;
  logic                         steady_two;
  logic                         steady_three;

  modport source (output valid, output level_zero, output level_one, output level_two,
                  output level_three, output steady_zero, output steady_one,
                  output steady_two, output steady_three, input ready);
  modport sink   (input valid, input level_zero, input level_one, input level_two,
                  input level_three, input steady_zero, input steady_one,
                  input steady_two, input steady_three, output ready);
endinterface

### hw/rtl/ebsd_lane.sv
// One EMA filter lane: filter state, settle counter and result computation.
module ebsd_lane (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ebsd_pkg::lane_ctrl_t                   ctrl,
  input  ebsd_pkg::lane_cfg_t                    cfg,
  input  logic [ebsd_pkg::GAIN_BITS-1:0]         gain,
  input  logic signed [ebsd_pkg::SAMPLE_BITS-1:0] sample,
  output ebsd_pkg::lane_res_t                    res
);
  import ebsd_pkg::*;

  logic signed [SAMPLE_BITS-1:0]   level_r;
  logic signed [SAMPLE_BITS-1:0]   level_nxt;
  logic [COUNT_BITS-1:0]           cnt_r;
  logic [COUNT_BITS-1:0]           cnt_nxt;
  logic signed [SAMPLE_BITS-1:0]   old_eff;
  logic [COUNT_BITS-1:0]           cnt_eff;
  logic signed [DIFF_BITS-1:0]     diff;
  logic [DIFF_BITS-1:0]            dist_abs;
  logic                            close;
  logic [GAIN_BITS-1:0]            gain_eff;
  logic signed [PROD_BITS-1:0]     prod;
  logic signed [DIFF_BITS-1:0]     step;
  logic signed [DIFF_BITS-1:0]     level_sum;
  logic signed [OUT_CALC_BITS-1:0] level_diff;

  // Before the first sample the filter behaves as if loaded with that sample.
  assign old_eff = ctrl.primed ? level_r : sample;
  assign cnt_eff = ctrl.primed ? cnt_r : '0;

  // Distance between the old filter value and the sample.
  assign diff     = DIFF_BITS'(sample) - DIFF_BITS'(old_eff);
  assign dist_abs = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
  assign close    = CMP_BITS'(dist_abs) < CMP_BITS'(cfg.threshold);

  // Settle counter rises while close, saturating, and clears otherwise.
  always_comb begin
    if (!close) begin
      cnt_nxt = '0;
    end else if (cnt_eff == COUNTER_MAX) begin
      cnt_nxt = COUNTER_MAX;
    end else begin
      cnt_nxt = cnt_eff + COUNT_BITS'(1);
    end
  end

  // Filter update: old + floor((sample - old) * gain / 2^16), gain clamped to one.
  assign gain_eff  = gain[GAIN_BITS-1] ? GAIN_UNITY : gain;
  assign prod      = PROD_BITS'(diff) * PROD_BITS'(signed'({1'b0, gain_eff}));
  assign step      = prod[GAIN_FRAC +: DIFF_BITS];
  assign level_sum = DIFF_BITS'(old_eff) + step;
  assign level_nxt = level_sum[SAMPLE_BITS-1:0];

  // Result fields for this lane.
  assign level_diff = OUT_CALC_BITS'(level_nxt) - OUT_CALC_BITS'(cfg.tare);
  assign res.level  = level_diff[LEVEL_BITS-1:0];
  assign res.steady = cnt_nxt >= cfg.settle_count;

  // Filter state advances once per transaction moved to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.advance) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      level_r <= level_nxt;
    end
  end

  // A sample that is not close clears the counter.
  a_clear_far: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance && !close |=> cnt_r == '0)
    else $error("settle counter not cleared after a far sample");

  // A close sample always leaves a nonzero count.
  a_rise_close: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance && close |=> cnt_r != '0)
    else $error("settle counter zero after a close sample");

  // The counter holds between transactions.
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.advance |=> $stable(cnt_r))
    else $error("settle counter changed without a transaction");

endmodule

### hw/rtl/ema_bank_stability_detector.sv
// A sample is registered in the input register and then in the output register, where
// its result is held until the output channel takes it.
// Throughput: one sample per cycle while the output is not stalled; each lane's multiply-add is combinational.
// The input register and the output register let a new sample enter while a result waits.
// Reset (synchronous, rst_n low) clears the handshake state, the settle counters and the
// primed flag and restores the default gains, tare, threshold and settle count.
module ema_bank_stability_detector (
  input  logic                                   clk,
  input  logic                                   rst_n,
  ebsd_in_if.sink                                in_ch,
  ebsd_out_if.source                             out_ch,
  input  logic                                   cfg_we,
  input  logic [ebsd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [ebsd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
  import ebsd_pkg::*;

  logic [GAIN_BITS-1:0]          gain_r [NUM_FILTERS];
  logic signed [TARE_BITS-1:0]   tare_r;
  logic [THRESH_BITS-1:0]        thresh_r;
  logic [COUNT_BITS-1:0]         count_r;
  logic                          primed_r;
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          out_valid_r;
  lane_res_t                     res_r [NUM_FILTERS];
  lane_res_t                     res_nxt [NUM_FILTERS];
  lane_cfg_t                     lane_cfg;
  lane_ctrl_t                    lane_ctrl;
  logic                          advance;

  // Configuration register writes; indexes past the map are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        gain_r[i] <= gain_default(i);
      end
      tare_r   <= '0;
      thresh_r <= THRESH_RESET;
      count_r  <= COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index <= REG_GAIN_LAST) begin
        gain_r[cfg_index[GAIN_IDX_BITS-1:0]] <= cfg_wdata[GAIN_BITS-1:0];
      end else begin
        unique case (cfg_index)
          REG_TARE:      tare_r   <= cfg_wdata[TARE_BITS-1:0];
          REG_THRESHOLD: thresh_r <= cfg_wdata[THRESH_BITS-1:0];
          REG_COUNT:     count_r  <= cfg_wdata[COUNT_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Pipeline handshake: the input stage moves on when the output register is empty or its result is taken.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        primed_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sample;
    end
  end

  // Filter lanes.
  assign lane_cfg.tare         = tare_r;
  assign lane_cfg.threshold    = thresh_r;
  assign lane_cfg.settle_count = count_r;
  assign lane_ctrl.advance     = advance;
  assign lane_ctrl.primed      = primed_r;

  for (genvar g = 0; g < NUM_FILTERS; g++) begin : g_lane
    ebsd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .cfg    (lane_cfg),
      .gain   (gain_r[g]),
      .sample (s1_sample_r),
      .res    (res_nxt[g])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.level_zero   = res_r[0].level;
  assign out_ch.level_one    = res_r[1].level;
  assign out_ch.level_two    = res_r[2].level;
  assign out_ch.level_three  = res_r[3].level;
  assign out_ch.steady_zero  = res_r[0].steady;
  assign out_ch.steady_one   = res_r[1].steady;
  assign out_ch.steady_two   = res_r[2].steady;
  assign out_ch.steady_three = res_r[3].steady;

  // The bank is primed after the first transaction reaches the output register.
  a_primed: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> primed_r)
    else $error("bank not primed after a transaction");

  // A result leaves when taken and is not replaced without a new transaction.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !advance && (out_ch.ready || !out_valid_r) |=> !out_valid_r)
    else $error("output valid without a new transaction");

  // An empty output register never blocks the input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while the output register is empty");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the EMA bank stability detector.
`timescale 1ns / 1ps

module tb_top;
  import ebsd_pkg::*;

  // Run length and register map names used by the stimulus.
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_SAMPLES = 1450;
  localparam int PAUSE_AT       = 700;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_ZERO  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_ONE   = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_TWO   = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_THREE = REG_GAIN_LAST;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE      = CFG_INDEX_BITS'(NUM_CFG_REGS);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
  localparam longint Q16_ONE     = 65536;
  localparam longint SAMPLE_BIAS = 64'sd1 << (SAMPLE_BITS - 1);

  // One result of the bank: a level and a stable flag per filter.
  typedef struct packed {
    logic [NUM_FILTERS-1:0][LEVEL_BITS-1:0] levels;
    logic [NUM_FILTERS-1:0]                 steady;
  } reading_t;

  // One row of the directed stimulus table.
  typedef struct {
    bit                            is_write;
    logic [CFG_INDEX_BITS-1:0]     idx;
    logic [CFG_DATA_BITS-1:0]      data;
    logic signed [SAMPLE_BITS-1:0] sample;
    bit                            known;
    reading_t                      want;
  } step_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  ebsd_in_if  in_if ();
  ebsd_out_if out_if ();

  ema_bank_stability_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: register copies and filter bank state.
  logic [GAIN_BITS-1:0]         gain_q16 [NUM_FILTERS];
  logic signed [TARE_BITS-1:0]  tare_val;
  logic [THRESH_BITS-1:0]       settle_thr;
  logic [COUNT_BITS-1:0]        settle_min;
  longint                       bank_level [NUM_FILTERS];
  int                           bank_count [NUM_FILTERS];
  bit                           bank_primed;

  reading_t  expected_readings [$];
  step_row_t steps [$];
  int        mismatch_count;
  int        since_idle;
  int        cycle_count;
  bit        writes_open;
  bit        calm;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the predicted filter bank by one sample and return its reading.
  function automatic reading_t filter_bank_step(input logic signed [SAMPLE_BITS-1:0] smp);
    longint   s;
    longint   old;
    longint   span;
    longint   g;
    longint   sum;
    longint   tare;
    longint   thr;
    reading_t r;
    s    = smp;
    tare = tare_val;
    thr  = settle_thr;
    if (!bank_primed) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        bank_level[i] = s;
        bank_count[i] = 0;
      end
      bank_primed = 1'b1;
    end
    for (int i = 0; i < NUM_FILTERS; i++) begin
      old  = bank_level[i];
      span = (old > s) ? old - s : s - old;
      g    = gain_q16[i];
      if (g > Q16_ONE) begin
        g = Q16_ONE;
      end
      // The counter rises, saturating, while the sample stays close to the old level, and clears otherwise.
      if (span < thr) begin
        if (bank_count[i] < int'(COUNTER_MAX)) begin
          bank_count[i]++;
        end
      end else begin
        bank_count[i] = 0;
      end
      // Offset both operands so the floor of the shift is toward minus infinity.
      sum = (old + SAMPLE_BIAS) * (Q16_ONE - g) + (s + SAMPLE_BIAS) * g;
      bank_level[i] = (sum >> GAIN_FRAC) - SAMPLE_BIAS;
      r.levels[i] = LEVEL_BITS'(bank_level[i] - tare);
      r.steady[i] = (bank_count[i] >= int'(settle_min));
    end
    return r;
  endfunction

  // A reading with the same level and flag on every filter.
  function automatic reading_t flat_reading(input int lvl, input bit st);
    reading_t r;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      r.levels[i] = LEVEL_BITS'(lvl);
    end
    r.steady = {NUM_FILTERS{st}};
    return r;
  endfunction

  function automatic step_row_t row_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    step_row_t r;
    r = '{is_write: 1'b1, idx: idx, data: data, sample: '0, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic step_row_t row_sample(input logic signed [SAMPLE_BITS-1:0] s);
    step_row_t r;
    r = '{is_write: 1'b0, idx: '0, data: '0, sample: s, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic step_row_t row_known(input logic signed [SAMPLE_BITS-1:0] s,
                                          input int lvl, input bit st);
    step_row_t r;
    r = '{is_write: 1'b0, idx: '0, data: '0, sample: s, known: 1'b1,
          want: flat_reading(lvl, st)};
    return r;
  endfunction

  // Drop the write enable once a burst of register writes is over.
  task automatic close_writes();
    if (writes_open) begin
      cfg_we <= 1'b0;
      writes_open = 1'b0;
    end
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx < NUM_FILTERS) begin
      gain_q16[idx] = data[GAIN_BITS-1:0];
    end else if (idx == REG_TARE) begin
      tare_val = data[TARE_BITS-1:0];
    end else if (idx == REG_THRESHOLD) begin
      settle_thr = data[THRESH_BITS-1:0];
    end else if (idx == REG_COUNT) begin
      settle_min = data[COUNT_BITS-1:0];
    end
    @(posedge clk);
    writes_open = 1'b1;
  endtask

  // Hold off the sender until every expected reading has come out.
  task automatic drain_bank();
    close_writes();
    in_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    since_idle = 0;
  endtask

  // Send one sample transaction and record its expected reading.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit known,
                             input reading_t want);
    int       gap;
    reading_t predicted;
    close_writes();
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = filter_bank_step(s);
    expected_readings.push_back(known ? want : predicted);
    since_idle++;
  endtask

  // Result side: random stalls, then compare each transaction with the oldest expectation.
  initial begin : result_monitor
    int       stall;
    reading_t got;
    reading_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      got.levels[0] = out_if.level_zero;
      got.levels[1] = out_if.level_one;
      got.levels[2] = out_if.level_two;
      got.levels[3] = out_if.level_three;
      got.steady    = {out_if.steady_three, out_if.steady_two,
                       out_if.steady_one, out_if.steady_zero};
      if (expected_readings.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        for (int i = 0; i < NUM_FILTERS; i++) begin
          if (got.levels[i] !== want.levels[i]) begin
            $display("%0t: level %0d mismatch, expected %0d, actual %0d", $time, i,
                     $signed(want.levels[i]), $signed(got.levels[i]));
            mismatch_count++;
          end
          if (got.steady[i] !== want.steady[i]) begin
            $display("%0t: steady %0d mismatch, expected %b, actual %b", $time, i,
                     want.steady[i], got.steady[i]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ema_bank_stability_detector test failed");
    $finish;
  end

  // Stimulus: reset, directed table, then randomized phases.
  initial begin : stimulus
    logic signed [SAMPLE_BITS-1:0] rnd;
    logic [CFG_DATA_BITS-1:0]      gains [NUM_FILTERS];
    logic [CFG_DATA_BITS-1:0]      tare_w;
    logic [CFG_DATA_BITS-1:0]      thr_w;
    logic [CFG_DATA_BITS-1:0]      count_w;
    int base;
    int amp;
    int v;
    int roll;
    int phase;
    int phase_len;
    int random_sent;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    out_if.ready <= 1'b0;
    mismatch_count = 0;
    since_idle     = 0;
    writes_open    = 1'b0;
    calm           = 1'b0;

    // Predictor reset values.
    gain_q16[0] = 17'd65536;
    gain_q16[1] = 17'd32768;
    gain_q16[2] = 17'd13107;
    gain_q16[3] = 17'd6554;
    tare_val    = '0;
    settle_thr  = 24'd3000;
    settle_min  = 8'd2;
    bank_primed = 1'b0;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      bank_level[i] = 0;
      bank_count[i] = 0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the first sample loads every filter; the second makes them stable.
    steps.push_back(row_known(SAMPLE_MAX, 8388607, 1'b0));
    steps.push_back(row_known(SAMPLE_MAX, 8388607, 1'b1));
    // Unity gains with the tare at both extremes give the widest levels.
    steps.push_back(row_write(REG_GAIN_ZERO, 24'd65536));
    steps.push_back(row_write(REG_GAIN_ONE, 24'd65536));
    steps.push_back(row_write(REG_GAIN_TWO, 24'd65536));
    steps.push_back(row_write(REG_GAIN_THREE, 24'd65536));
    steps.push_back(row_write(REG_TARE, 24'h800000));
    steps.push_back(row_known(SAMPLE_MAX, 16777215, 1'b1));
    steps.push_back(row_write(REG_TARE, 24'h7FFFFF));
    steps.push_back(row_known(SAMPLE_MIN, -16777215, 1'b0));
    steps.push_back(row_known(SAMPLE_MIN, -16777215, 1'b0));
    steps.push_back(row_known(SAMPLE_MIN, -16777215, 1'b1));
    // Zero gain, tiny gain, gains above one and a zero threshold.
    steps.push_back(row_write(REG_TARE, 24'h000000));
    steps.push_back(row_write(REG_GAIN_ZERO, 24'd0));
    steps.push_back(row_write(REG_GAIN_ONE, 24'd1));
    steps.push_back(row_write(REG_GAIN_TWO, 24'h01FFFF));
    steps.push_back(row_write(REG_GAIN_THREE, 24'hFFFFFF));
    steps.push_back(row_write(REG_THRESHOLD, 24'd0));
    steps.push_back(row_sample(SAMPLE_MAX));
    steps.push_back(row_sample(24'sd0));
    steps.push_back(row_sample(24'sd0));
    // A zero settle count flags every filter; the spare index must change nothing.
    steps.push_back(row_write(REG_COUNT, 24'd0));
    steps.push_back(row_write(REG_SPARE, 24'hFFFFFF));
    steps.push_back(row_sample(24'sd0));
    steps.push_back(row_sample(-24'sd1));
    // Widest threshold with the largest settle count.
    steps.push_back(row_write(REG_THRESHOLD, 24'hFFFFFF));
    steps.push_back(row_write(REG_COUNT, 24'd255));
    steps.push_back(row_write(REG_GAIN_ZERO, 24'd32768));
    steps.push_back(row_write(REG_GAIN_ONE, 24'd49152));
    steps.push_back(row_write(REG_GAIN_TWO, 24'd65535));
    steps.push_back(row_write(REG_GAIN_THREE, 24'd1));
    steps.push_back(row_sample(24'sd100));
    steps.push_back(row_sample(-24'sd100));
    steps.push_back(row_sample(SAMPLE_MAX));
    steps.push_back(row_sample(SAMPLE_MIN));
    // Threshold of one: only an exact match counts.
    steps.push_back(row_write(REG_COUNT, 24'd1));
    steps.push_back(row_write(REG_THRESHOLD, 24'd1));
    steps.push_back(row_sample(SAMPLE_MIN));
    steps.push_back(row_sample(SAMPLE_MIN));
    steps.push_back(row_sample(SAMPLE_MIN + 24'sd1));
    // Back to the reset settings around the default threshold.
    steps.push_back(row_write(REG_GAIN_ZERO, 24'd65536));
    steps.push_back(row_write(REG_GAIN_ONE, 24'd32768));
    steps.push_back(row_write(REG_GAIN_TWO, 24'd13107));
    steps.push_back(row_write(REG_GAIN_THREE, 24'd6554));
    steps.push_back(row_write(REG_THRESHOLD, 24'd3000));
    steps.push_back(row_write(REG_COUNT, 24'd2));
    steps.push_back(row_sample(24'sd1));
    steps.push_back(row_sample(24'sd3001));
    steps.push_back(row_sample(24'sd5999));
    steps.push_back(row_sample(24'sd5999));

    foreach (steps[k]) begin
      if (steps[k].is_write) begin
        if (since_idle != 0) begin
          drain_bank();
        end
        write_reg(steps[k].idx, steps[k].data);
      end else begin
        send_sample(steps[k].sample, steps[k].known, steps[k].want);
      end
    end

    // Random phases: new settings, then a settling load with jumps and noise.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      drain_bank();
      for (int f = 0; f < NUM_FILTERS; f++) begin
        case ($urandom_range(0, 9))
          0:       gains[f] = 24'd0;
          1:       gains[f] = 24'd65536;
          2:       gains[f] = CFG_DATA_BITS'($urandom);
          default: gains[f] = CFG_DATA_BITS'($urandom_range(0, 65536));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        tare_w = CFG_DATA_BITS'($urandom);
      end else begin
        tare_w = CFG_DATA_BITS'(int'($urandom_range(0, 2000)) - 1000);
      end
      case ($urandom_range(0, 5))
        0:       thr_w = 24'd0;
        1:       thr_w = CFG_DATA_BITS'($urandom_range(1, 64));
        2:       thr_w = 24'd3000;
        3:       thr_w = CFG_DATA_BITS'($urandom_range(0, 200000));
        4:       thr_w = 24'hFFFFFF;
        default: thr_w = CFG_DATA_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       count_w = 24'd0;
        1:       count_w = 24'd255;
        2:       count_w = CFG_DATA_BITS'($urandom_range(1, 8));
        default: count_w = CFG_DATA_BITS'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       amp = 0;
        1:       amp = 4;
        2:       amp = 300;
        3:       amp = 4000;
        default: amp = 70000;
      endcase
      phase_len = $urandom_range(10, 90);
      // The first phase runs long enough for the counters to saturate.
      if (phase == 0) begin
        thr_w     = 24'hFFFFFF;
        count_w   = 24'd255;
        amp       = 4;
        phase_len = 300;
      end
      for (int f = 0; f < NUM_FILTERS; f++) begin
        if (phase == 0 || $urandom_range(0, 2) != 0) begin
          write_reg(CFG_INDEX_BITS'(f), gains[f]);
        end
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(REG_TARE, tare_w);
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(REG_THRESHOLD, thr_w);
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(REG_COUNT, count_w);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
      end
      calm = ($urandom_range(0, 3) == 0);
      rnd  = SAMPLE_BITS'($urandom);
      base = rnd;

      for (int n = 0; n < phase_len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          // The load steps to a new level.
          rnd  = SAMPLE_BITS'($urandom);
          base = rnd;
        end else if (roll < 8) begin
          // A single glitch over the whole range.
          rnd = SAMPLE_BITS'($urandom);
        end else begin
          v = base + int'($urandom_range(0, 2 * amp)) - amp;
          if (v > 8388607) begin
            v = 8388607;
          end
          if (v < -8388608) begin
            v = -8388608;
          end
          rnd = SAMPLE_BITS'(v);
        end
        send_sample(rnd, 1'b0, '0);
        random_sent++;
        // Once in the run the sender waits for the bank to empty mid-phase.
        if (random_sent == PAUSE_AT) begin
          drain_bank();
        end
      end
      phase++;
    end

    drain_bank();
    if (mismatch_count == 0) begin
      $display("ema_bank_stability_detector test passed");
    end else begin
      $display("ema_bank_stability_detector test failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ebsd_pkg.sv
hw/rtl/ebsd_if.sv
hw/rtl/ebsd_lane.sv
hw/rtl/ema_bank_stability_detector.sv
sim/tb_top.sv
